/* src/psse_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psse_pkg: shared types and constants of the subpicture extractor
// Stream type codes, parse phases, finish codes and the item and result
// records passed between the parser, the result stage and the top level.
// ----------------------------------------------------------------------------
package psse_pkg;

    // program stream type bytes that follow the start code
    localparam logic [7:0] KIND_PACK    = 8'hBA;
    localparam logic [7:0] KIND_PRIV1   = 8'hBD;
    localparam logic [7:0] KIND_PADDING = 8'hBE;
    localparam logic [7:0] KIND_NAV     = 8'hBF;

    // field masks taken from header bytes
    localparam logic [7:0] PACK_STUFF_MASK = 8'h07;

    // offsets within a packet
    localparam int unsigned POS_KIND      = 3;
    localparam int unsigned POS_LEN_HI    = 4;
    localparam int unsigned POS_LEN_LO    = 5;
    localparam int unsigned POS_HDR_LEN   = 8;
    localparam int unsigned POS_SUBSTREAM = 9;
    localparam int unsigned POS_STUFF     = 13;

    localparam int unsigned POS_BITS = 17;

    localparam logic [15:0] PAYLOAD_MAX   = 16'hFFFF;
    localparam logic [19:0] CONSUMED_MAX  = 20'hFFFFF;

    // configuration register indexes
    localparam logic REG_AUTO_SELECT     = 1'b0;
    localparam logic REG_SUBSTREAM_INDEX = 1'b1;

    typedef enum logic [1:0] {
        PH_HEAD = 2'd0,
        PH_BODY = 2'd1,
        PH_COPY = 2'd2,
        PH_DONE = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ST_END      = 2'd0,
        ST_COMPLETE = 2'd1,
        ST_BADSTART = 2'd2,
        ST_UNKNOWN  = 2'd3
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       frame_start;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        payload_valid;
        logic        done_res;
        status_t     status;
        logic [15:0] copied_count;
        logic [19:0] consumed_count;
    } result_t;

endpackage

/* src/psse_parser.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psse_parser: program stream framing parser
// Keeps parse state and, with item_valid high, works out one source byte per cycle:
// start code check, header skipping, substream match, payload copy, size tracking.
// ----------------------------------------------------------------------------
module psse_parser #(
    parameter int COUNT_BITS = 20
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              item_valid,
    input  psse_pkg::item_t   item,
    input  logic              auto_select,
    input  logic [4:0]        substream_index,
    output logic              res_valid,
    output psse_pkg::result_t res
);

    localparam int PB = psse_pkg::POS_BITS;

    psse_pkg::phase_t        phase_reg, phase_next, phase_cur;
    logic [PB-1:0]           pos_reg, pos_next, pos_cur;
    logic [15:0]             pkt_len_reg, pkt_len_next, pkt_len_cur;
    logic [7:0]              hdr_len_reg, hdr_len_next, hdr_len_cur;
    logic [7:0]              kind_reg, kind_next, kind_cur;
    logic [4:0]              lock_idx_reg, lock_idx_next, lock_idx_cur;
    logic                    locked_reg, locked_next, locked_cur;
    logic [15:0]             pay_cnt_reg, pay_cnt_next, pay_cnt_cur;
    logic [15:0]             sp_size_reg, sp_size_next, sp_size_cur;
    logic                    size_known_reg, size_known_next, size_known_cur;
    logic [COUNT_BITS-1:0]   src_cnt_reg, src_cnt_next, src_cnt_cur;

    logic                    emit, done, boundary, lock_take;
    psse_pkg::status_t       status;
    logic [7:0]              b, hl_eff;
    logic [15:0]             pl_eff;
    logic [4:0]              idx, want;
    logic [PB-1:0]           sub_pos;
    logic [32:0]             src_ext;

    assign b = item.data_byte;

    // a new buffer restarts the parse before this byte is looked at
    always_comb begin
        if (item.frame_start) begin
            phase_cur      = psse_pkg::PH_HEAD;
            pos_cur        = '0;
            pkt_len_cur    = '0;
            hdr_len_cur    = '0;
            kind_cur       = '0;
            lock_idx_cur   = '0;
            locked_cur     = 1'b0;
            pay_cnt_cur    = '0;
            sp_size_cur    = 16'hFFFF;
            size_known_cur = 1'b0;
            src_cnt_cur    = '0;
        end else begin
            phase_cur      = phase_reg;
            pos_cur        = pos_reg;
            pkt_len_cur    = pkt_len_reg;
            hdr_len_cur    = hdr_len_reg;
            kind_cur       = kind_reg;
            lock_idx_cur   = lock_idx_reg;
            locked_cur     = locked_reg;
            pay_cnt_cur    = pay_cnt_reg;
            sp_size_cur    = sp_size_reg;
            size_known_cur = size_known_reg;
            src_cnt_cur    = src_cnt_reg;
        end
    end

    assign sub_pos = PB'(psse_pkg::POS_SUBSTREAM) + PB'(hdr_len_cur);
    assign idx     = b[4:0];

    always_comb begin
        phase_next      = phase_cur;
        pos_next        = pos_cur;
        pkt_len_next    = pkt_len_cur;
        hdr_len_next    = hdr_len_cur;
        kind_next       = kind_cur;
        lock_idx_next   = lock_idx_cur;
        locked_next     = locked_cur;
        pay_cnt_next    = pay_cnt_cur;
        sp_size_next    = sp_size_cur;
        size_known_next = size_known_cur;
        src_cnt_next    = src_cnt_cur;
        emit            = 1'b0;
        done            = 1'b0;
        boundary        = 1'b0;
        status          = psse_pkg::ST_END;
        lock_take       = 1'b0;
        want            = substream_index;
        hl_eff          = hdr_len_cur;
        pl_eff          = pkt_len_cur;

        if (phase_cur != psse_pkg::PH_DONE) begin
            if (src_cnt_cur != {COUNT_BITS{1'b1}}) begin
                src_cnt_next = src_cnt_cur + COUNT_BITS'(1);
            end

            if (pos_cur < PB'(4)) begin
                // start code 00 00 01 then the type byte
                if ((pos_cur < PB'(2) && b != 8'h00) || (pos_cur == PB'(2) && b != 8'h01)) begin
                    done   = 1'b1;
                    status = psse_pkg::ST_BADSTART;
                end else if (pos_cur == PB'(psse_pkg::POS_KIND)) begin
                    kind_next = b;
                    if (b != psse_pkg::KIND_PACK && b != psse_pkg::KIND_PRIV1 &&
                        b != psse_pkg::KIND_PADDING && b != psse_pkg::KIND_NAV) begin
                        done   = 1'b1;
                        status = psse_pkg::ST_UNKNOWN;
                    end else begin
                        phase_next = psse_pkg::PH_BODY;
                    end
                end
            end else if (kind_cur == psse_pkg::KIND_PACK) begin
                if (pos_cur == PB'(psse_pkg::POS_STUFF)) begin
                    hl_eff = b & psse_pkg::PACK_STUFF_MASK;
                end
                hdr_len_next = hl_eff;
                if (pos_cur >= PB'(psse_pkg::POS_STUFF) &&
                    pos_cur == PB'(psse_pkg::POS_STUFF) + PB'(hl_eff)) begin
                    boundary = 1'b1;
                end
            end else begin
                if (pos_cur == PB'(psse_pkg::POS_LEN_HI)) begin
                    pl_eff = {b, 8'h00};
                end else if (pos_cur == PB'(psse_pkg::POS_LEN_LO)) begin
                    pl_eff = {pkt_len_cur[15:8], b};
                end
                pkt_len_next = pl_eff;

                if (kind_cur == psse_pkg::KIND_PRIV1) begin
                    if (pos_cur == PB'(psse_pkg::POS_HDR_LEN)) begin
                        hdr_len_next = b;
                    end else if (pos_cur > PB'(psse_pkg::POS_HDR_LEN) && pos_cur == sub_pos) begin
                        lock_take = auto_select && !locked_cur;
                        if (lock_take) begin
                            lock_idx_next = idx;
                            locked_next   = 1'b1;
                        end
                        if (auto_select) begin
                            want = lock_take ? idx : lock_idx_cur;
                        end
                        if (idx == want) begin
                            phase_next = psse_pkg::PH_COPY;
                        end
                    end else if (phase_cur == psse_pkg::PH_COPY && pos_cur > sub_pos) begin
                        emit = 1'b1;
                        // first two payload bytes carry the subpicture size, big endian
                        if (pay_cnt_cur == 16'd0) begin
                            sp_size_next = {b, 8'hFF};
                        end else if (pay_cnt_cur == 16'd1) begin
                            sp_size_next    = {sp_size_cur[15:8], b};
                            size_known_next = 1'b1;
                        end
                        if (pay_cnt_cur != psse_pkg::PAYLOAD_MAX) begin
                            pay_cnt_next = pay_cnt_cur + 16'd1;
                        end
                    end
                end
                if (pos_cur >= PB'(psse_pkg::POS_LEN_LO) &&
                    pos_cur == PB'(psse_pkg::POS_LEN_LO) + PB'(pl_eff)) begin
                    boundary = 1'b1;
                end
            end

            if (!done) begin
                if (boundary) begin
                    pos_next   = '0;
                    phase_next = psse_pkg::PH_HEAD;
                    if (size_known_next && pay_cnt_next >= sp_size_next) begin
                        done   = 1'b1;
                        status = psse_pkg::ST_COMPLETE;
                    end
                end else begin
                    pos_next = pos_cur + PB'(1);
                end
                if (!done && item.last_byte) begin
                    done   = 1'b1;
                    status = psse_pkg::ST_END;
                end
            end
            if (done) begin
                phase_next = psse_pkg::PH_DONE;
            end
        end
    end

    assign src_ext = 33'(src_cnt_next);

    always_comb begin
        res.payload_byte   = emit ? b : 8'h00;
        res.payload_valid  = emit;
        res.done_res       = done;
        res.status         = done ? status : psse_pkg::ST_END;
        res.copied_count   = pay_cnt_next;
        res.consumed_count = (src_ext > 33'(psse_pkg::CONSUMED_MAX)) ?
                             psse_pkg::CONSUMED_MAX : src_ext[19:0];
    end

    assign res_valid = item_valid && (emit || done);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= psse_pkg::PH_HEAD;
            pos_reg        <= '0;
            pkt_len_reg    <= '0;
            hdr_len_reg    <= '0;
            kind_reg       <= '0;
            lock_idx_reg   <= '0;
            locked_reg     <= 1'b0;
            pay_cnt_reg    <= '0;
            sp_size_reg    <= 16'hFFFF;
            size_known_reg <= 1'b0;
            src_cnt_reg    <= '0;
        end else if (item_valid) begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            pkt_len_reg    <= pkt_len_next;
            hdr_len_reg    <= hdr_len_next;
            kind_reg       <= kind_next;
            lock_idx_reg   <= lock_idx_next;
            locked_reg     <= locked_next;
            pay_cnt_reg    <= pay_cnt_next;
            sp_size_reg    <= sp_size_next;
            size_known_reg <= size_known_next;
            src_cnt_reg    <= src_cnt_next;
        end
    end

endmodule

/* src/psse_out_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psse_out_stage: result register
// Holds one result beat for the output channel and frees its slot in the
// same cycle the beat is taken.
// ----------------------------------------------------------------------------
module psse_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  psse_pkg::result_t load_res,
    input  logic              out_ready,
    output logic              out_valid,
    output psse_pkg::result_t out_res,
    output logic              can_take
);

    logic              valid_reg, valid_next;
    psse_pkg::result_t res_reg;

    assign can_take = !valid_reg || out_ready;

    always_comb begin
        valid_next = valid_reg;
        if (valid_reg && out_ready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= load_res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

/* src/program_stream_subpicture_extract_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// program_stream_subpicture_extract_top: subpicture extractor top level
// Input beat register, framing parser, result register and config registers.
// ----------------------------------------------------------------------------
// Takes one source byte per clock cycle with no gap as long as the result
// side keeps up; while a result beat waits on the output with m_tready low,
// the input register holds its byte and s_tready drops. Each byte passes an
// input register, the parser (registering its state on each accepted byte) and
// a result register, in that order, before its result reaches the output.
// A beat is produced only for a copied payload byte or when the parse of the
// buffer finishes; bytes after the finish are swallowed until a beat with
// frame_start. Configuration is sampled by the parser, so write it only while
// the block is idle.
module program_stream_subpicture_extract_top #(
    parameter int COUNT_BITS = 20
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_wdata,
    // source byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] frame_start
    input  logic        s_tlast,   // last_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [7:0] payload_byte, [23:8] copied_count,
                                   // [43:24] consumed_count, [47:44] zero
    output logic [2:0]  m_tuser,   // [0] payload_valid, [2:1] status
    output logic        m_tlast    // done_res
);

    logic              auto_select_reg;
    logic [4:0]        substream_reg;
    logic              in_valid_reg;
    psse_pkg::item_t   item_reg;
    logic              advance, out_can_take, res_valid, out_valid;
    psse_pkg::result_t res, out_res;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            auto_select_reg <= 1'b1;
            substream_reg   <= 5'd0;
        end else if (cfg_we) begin
            case (cfg_index)
                psse_pkg::REG_AUTO_SELECT:     auto_select_reg <= cfg_wdata[0];
                psse_pkg::REG_SUBSTREAM_INDEX: substream_reg   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign advance  = in_valid_reg && out_can_take;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.data_byte   <= s_tdata;
            item_reg.frame_start <= s_tuser;
            item_reg.last_byte   <= s_tlast;
        end
    end

    psse_parser #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parser (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .item_valid      (advance),
        .item            (item_reg),
        .auto_select     (auto_select_reg),
        .substream_index (substream_reg),
        .res_valid       (res_valid),
        .res             (res)
    );

    psse_out_stage u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (res_valid),
        .load_res  (res),
        .out_ready (m_tready),
        .out_valid (out_valid),
        .out_res   (out_res),
        .can_take  (out_can_take)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = {4'h0, out_res.consumed_count, out_res.copied_count,
                       out_res.payload_byte};
    assign m_tuser  = {out_res.status, out_res.payload_valid};
    assign m_tlast  = out_res.done_res;

endmodule

/* src/psse_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psse_checker: port-level checks for the subpicture extractor
// Watches the result channel and flags beats that break the output rules.
// ----------------------------------------------------------------------------
module psse_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [2:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result beat changed while stalled");

    // every beat carries a payload byte or a finish
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser[0] || m_tlast)
        else $error("empty result beat");

    // status is only reported on the finishing beat
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> m_tuser[2:1] == 2'd0)
        else $error("status set on a beat that does not finish");

    // payload byte is zero when no payload is carried
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata[7:0] == 8'h00)
        else $error("payload byte set without payload_valid");

endmodule

bind program_stream_subpicture_extract_top psse_checker u_psse_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

/* verif/tb_program_stream_subpicture_extract_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_program_stream_subpicture_extract_top: subpicture extractor testbench
// Feeds framed program-stream buffers (pack headers, padding and navigation
// packets, private stream 1 packets carrying a subpicture, plus broken and
// noisy buffers) and checks every result beat against a cycle-free parser
// model updated on each accepted source byte, under random stalls and
// several substream selection settings.
// ----------------------------------------------------------------------------
module tb_program_stream_subpicture_extract_top;

    // a type byte outside the four that the parser knows
    localparam logic [7:0] KIND_BOGUS = 8'hB9;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_index = psse_pkg::REG_AUTO_SELECT;
    logic [4:0]  cfg_wdata = 5'd0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] data_byte
    logic        s_tuser = 1'b0;    // [0] frame_start
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;           // [7:0] payload_byte, [23:8] copied_count,
                                    // [43:24] consumed_count
    logic [2:0]  m_tuser;           // [0] payload_valid, [2:1] status
    logic        m_tlast;

    program_stream_subpicture_extract_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // parser model state and its copy of the registers
    // ------------------------------------------------------------------
    psse_pkg::phase_t              ps_phase;
    logic [psse_pkg::POS_BITS-1:0] ps_pos;
    logic [15:0]                   ps_pkt_len;
    logic [7:0]                    ps_hdr_len;
    logic [7:0]                    ps_kind;
    logic [4:0]                    ps_lock_sub;
    logic                          ps_locked;
    logic [15:0]                   ps_copied;
    logic [15:0]                   ps_spic_size;
    logic                          ps_size_known;
    logic [19:0]                   ps_consumed;
    logic                          ps_auto;
    logic [4:0]                    ps_sub;

    psse_pkg::item_t   pending[$];
    psse_pkg::result_t expected_results[$];
    logic [7:0] byte_buf[$];
    logic [7:0] spic_bytes[$];

    int  beats_taken = 0;
    int  mismatches = 0;
    int  hold_left = 0;
    bit  hold_used = 0;
    logic stim_auto = 1'b1;
    logic [4:0] stim_sub = 5'd0;
    logic calm;

    // no random stalls on either side over this stretch
    assign calm = beats_taken >= 700 && beats_taken < 950;

    function automatic void clear_parser();
        ps_phase = psse_pkg::PH_HEAD;
        ps_pos = '0;
        ps_pkt_len = '0;
        ps_hdr_len = '0;
        ps_kind = '0;
        ps_lock_sub = '0;
        ps_locked = 1'b0;
        ps_copied = '0;
        ps_spic_size = 16'hFFFF;
        ps_size_known = 1'b0;
        ps_consumed = '0;
    endfunction

    task automatic parse_source_byte(input psse_pkg::item_t it, output bit fired,
                                     output psse_pkg::result_t res);
        int unsigned p;
        logic [7:0] b;
        logic [4:0] sub;
        logic [4:0] chosen;
        bit emit;
        bit fin;
        bit at_boundary;
        psse_pkg::status_t code;
        b = it.data_byte;
        emit = 1'b0;
        fin = 1'b0;
        at_boundary = 1'b0;
        code = psse_pkg::ST_END;
        fired = 1'b0;
        res = '0;
        if (it.frame_start)
            clear_parser();
        if (ps_phase != psse_pkg::PH_DONE) begin
            if (ps_consumed != psse_pkg::CONSUMED_MAX)
                ps_consumed = ps_consumed + 1'b1;
            p = 32'(ps_pos);
            if (p < psse_pkg::POS_LEN_HI) begin
                if ((p < 2 && b != 8'h00) || (p == 2 && b != 8'h01)) begin
                    fin = 1'b1;
                    code = psse_pkg::ST_BADSTART;
                end else if (p == psse_pkg::POS_KIND) begin
                    ps_kind = b;
                    if (b != psse_pkg::KIND_PACK && b != psse_pkg::KIND_PRIV1 &&
                        b != psse_pkg::KIND_PADDING && b != psse_pkg::KIND_NAV) begin
                        fin = 1'b1;
                        code = psse_pkg::ST_UNKNOWN;
                    end else begin
                        ps_phase = psse_pkg::PH_BODY;
                    end
                end
            end else if (ps_kind == psse_pkg::KIND_PACK) begin
                if (p == psse_pkg::POS_STUFF)
                    ps_hdr_len = b & psse_pkg::PACK_STUFF_MASK;
                if (p >= psse_pkg::POS_STUFF && p == psse_pkg::POS_STUFF + ps_hdr_len)
                    at_boundary = 1'b1;
            end else begin
                if (p == psse_pkg::POS_LEN_HI)
                    ps_pkt_len = {b, 8'h00};
                else if (p == psse_pkg::POS_LEN_LO)
                    ps_pkt_len[7:0] = b;
                if (ps_kind == psse_pkg::KIND_PRIV1) begin
                    if (p == psse_pkg::POS_HDR_LEN) begin
                        ps_hdr_len = b;
                    end else if (p > psse_pkg::POS_HDR_LEN &&
                                 p == psse_pkg::POS_SUBSTREAM + ps_hdr_len) begin
                        sub = b[4:0];
                        if (ps_auto && !ps_locked) begin
                            ps_lock_sub = sub;
                            ps_locked = 1'b1;
                        end
                        chosen = ps_auto ? ps_lock_sub : ps_sub;
                        if (sub == chosen)
                            ps_phase = psse_pkg::PH_COPY;
                    end else if (ps_phase == psse_pkg::PH_COPY &&
                                 p > psse_pkg::POS_SUBSTREAM + ps_hdr_len) begin
                        emit = 1'b1;
                        // first two payload bytes carry the subpicture size, big endian
                        if (ps_copied == 16'd0) begin
                            ps_spic_size = {b, 8'hFF};
                        end else if (ps_copied == 16'd1) begin
                            ps_spic_size[7:0] = b;
                            ps_size_known = 1'b1;
                        end
                        if (ps_copied != psse_pkg::PAYLOAD_MAX)
                            ps_copied = ps_copied + 1'b1;
                    end
                end
                if (p >= psse_pkg::POS_LEN_LO && p == psse_pkg::POS_LEN_LO + ps_pkt_len)
                    at_boundary = 1'b1;
            end

            if (!fin) begin
                if (at_boundary) begin
                    ps_pos = '0;
                    ps_phase = psse_pkg::PH_HEAD;
                    if (ps_size_known && ps_copied >= ps_spic_size) begin
                        fin = 1'b1;
                        code = psse_pkg::ST_COMPLETE;
                    end
                end else begin
                    ps_pos = ps_pos + 1'b1;
                end
                if (!fin && it.last_byte) begin
                    fin = 1'b1;
                    code = psse_pkg::ST_END;
                end
            end
            if (fin)
                ps_phase = psse_pkg::PH_DONE;

            if (emit || fin) begin
                fired = 1'b1;
                res.payload_byte = emit ? b : 8'h00;
                res.payload_valid = emit;
                res.done_res = fin;
                res.status = fin ? code : psse_pkg::ST_END;
                res.copied_count = ps_copied;
                res.consumed_count = ps_consumed;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // source side: register copy, model update on accept, next beat
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : source_driver
        psse_pkg::item_t cur;
        psse_pkg::item_t nxt;
        psse_pkg::result_t res;
        bit fired;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            clear_parser();
            ps_auto = 1'b1;
            ps_sub = 5'd0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    psse_pkg::REG_AUTO_SELECT: ps_auto = cfg_wdata[0];
                    psse_pkg::REG_SUBSTREAM_INDEX: ps_sub = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                cur.data_byte = s_tdata;
                cur.frame_start = s_tuser;
                cur.last_byte = s_tlast;
                parse_source_byte(cur, fired, res);
                if (fired)
                    expected_results.push_back(res);
                beats_taken <= beats_taken + 1;
            end
            if (!s_tvalid || s_tready) begin
                if (pending.size() > 0 && (calm || $urandom_range(0, 99) >= 23)) begin
                    nxt = pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= nxt.data_byte;
                    s_tuser <= nxt.frame_start;
                    s_tlast <= nxt.last_byte;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // result side: ready with random stalls and one long hold-off
    // ------------------------------------------------------------------
    always @(posedge aclk) begin : result_ready
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (!hold_used && beats_taken >= 450) begin
            hold_used = 1'b1;
            hold_left = 300;
            m_tready <= 1'b0;
        end else begin
            m_tready <= calm || $urandom_range(0, 99) >= 23;
        end
    end

    task automatic compare_field(input string field, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: %s mismatch, expected %0h, got %0h", $realtime, field, want, got);
        end
    endtask

    always @(posedge aclk) begin : result_monitor
        psse_pkg::result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result beat with nothing expected, tdata %0h tuser %0h",
                             $realtime, m_tdata, m_tuser);
            end else begin
                want = expected_results.pop_front();
                compare_field("payload_byte", 32'(want.payload_byte), 32'(m_tdata[7:0]));
                compare_field("payload_valid", 32'(want.payload_valid), 32'(m_tuser[0]));
                compare_field("done_res", 32'(want.done_res), 32'(m_tlast));
                compare_field("status", 32'(want.status), 32'(m_tuser[2:1]));
                compare_field("copied_count", 32'(want.copied_count), 32'(m_tdata[23:8]));
                compare_field("consumed_count", 32'(want.consumed_count),
                              32'(m_tdata[43:24]));
            end
        end
    end

    // ------------------------------------------------------------------
    // buffer construction
    // ------------------------------------------------------------------
    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic put_start(input logic [7:0] kind_code);
        byte_buf.push_back(8'h00);
        byte_buf.push_back(8'h00);
        byte_buf.push_back(8'h01);
        byte_buf.push_back(kind_code);
    endtask

    task automatic add_pack_header();
        logic [7:0] stuff;
        stuff = 8'($urandom_range(0, 7));
        put_start(psse_pkg::KIND_PACK);
        repeat (9) byte_buf.push_back(rand_byte());
        byte_buf.push_back((rand_byte() & ~psse_pkg::PACK_STUFF_MASK) | stuff);
        repeat (stuff) byte_buf.push_back(rand_byte());
    endtask

    task automatic add_skip_packet(input logic [7:0] kind_code, input logic [15:0] len);
        put_start(kind_code);
        byte_buf.push_back(len[15:8]);
        byte_buf.push_back(len[7:0]);
        repeat (len) byte_buf.push_back(rand_byte());
    endtask

    task automatic add_private(input logic [4:0] sub, input int hl, input int n,
                               input bit from_spic);
        logic [15:0] len;
        logic [7:0] hl8;
        len = 16'(4 + hl + n);
        hl8 = 8'(hl);
        put_start(psse_pkg::KIND_PRIV1);
        byte_buf.push_back(len[15:8]);
        byte_buf.push_back(len[7:0]);
        byte_buf.push_back(rand_byte());
        byte_buf.push_back(rand_byte());
        byte_buf.push_back(hl8);
        repeat (hl) byte_buf.push_back(rand_byte());
        byte_buf.push_back({3'($urandom_range(0, 7)), sub});
        repeat (n) byte_buf.push_back(from_spic ? spic_bytes.pop_front() : rand_byte());
    endtask

    // private packet that ends before its substream byte: short or negative payload
    task automatic add_stub_private();
        logic [7:0] hl;
        logic [15:0] len;
        int i;
        hl = 8'($urandom_range(0, 20));
        len = 16'($urandom_range(0, 3 + hl));
        put_start(psse_pkg::KIND_PRIV1);
        byte_buf.push_back(len[15:8]);
        byte_buf.push_back(len[7:0]);
        for (i = 0; i < len; i++)
            byte_buf.push_back(i == 2 ? hl : rand_byte());
    endtask

    function automatic int pick_hdr_len();
        return ($urandom_range(0, 19) == 0) ? int'($urandom_range(0, 255)) :
                                              int'($urandom_range(0, 3));
    endfunction

    task automatic build_subpicture_buffer();
        int total;
        int r;
        int n;
        int limit;
        logic [15:0] size_val;
        logic [4:0] want;
        logic [4:0] other;
        bit locked;
        byte_buf.delete();
        spic_bytes.delete();
        r = int'($urandom_range(0, 99));
        if (r < 6) begin
            total = 2;
            size_val = 16'($urandom_range(0, 1));
        end else begin
            total = int'($urandom_range(2, 40));
            size_val = 16'(total);
            // size that the buffer never reaches
            if (r >= 97)
                size_val = 16'($urandom_range(256, 65535));
            else if (r >= 93)
                size_val = 16'(total + int'($urandom_range(1, 300)));
        end
        spic_bytes.push_back(size_val[15:8]);
        spic_bytes.push_back(size_val[7:0]);
        repeat (total - 2) spic_bytes.push_back(rand_byte());

        want = stim_auto ? 5'($urandom_range(0, 31)) : stim_sub;
        locked = 1'b0;
        if ($urandom_range(0, 1))
            add_pack_header();
        while (spic_bytes.size() > 0) begin
            r = int'($urandom_range(0, 99));
            if (r < 12) begin
                add_pack_header();
            end else if (r < 22) begin
                add_skip_packet($urandom_range(0, 1) ? psse_pkg::KIND_PADDING :
                                                       psse_pkg::KIND_NAV,
                                16'($urandom_range(0, 12)));
            end else if (r < 32 && (locked || !stim_auto)) begin
                other = want + 5'($urandom_range(1, 31));
                add_private(other, pick_hdr_len(), int'($urandom_range(0, 8)), 1'b0);
            end else if (r < 38) begin
                add_stub_private();
            end else begin
                limit = (spic_bytes.size() < 10) ? spic_bytes.size() : 10;
                n = int'($urandom_range(0, limit));
                add_private(want, pick_hdr_len(), n, 1'b1);
                locked = 1'b1;
            end
        end
        if ($urandom_range(0, 3) == 0)
            add_skip_packet(psse_pkg::KIND_PADDING, 16'($urandom_range(0, 4)));
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) byte_buf.push_back(rand_byte());
    endtask

    task automatic build_broken_buffer();
        byte_buf.delete();
        if ($urandom_range(0, 1))
            add_pack_header();
        else
            add_skip_packet($urandom_range(0, 1) ? psse_pkg::KIND_PADDING :
                                                   psse_pkg::KIND_NAV,
                            16'($urandom_range(0, 6)));
        case ($urandom_range(0, 2))
            0: begin
                put_start(rand_byte());
            end
            1: begin
                byte_buf.push_back(8'h00);
                byte_buf.push_back(rand_byte());
                byte_buf.push_back(rand_byte());
            end
            default: begin
                add_stub_private();
            end
        endcase
        repeat ($urandom_range(0, 3)) byte_buf.push_back(rand_byte());
    endtask

    task automatic build_noise_buffer();
        byte_buf.delete();
        repeat ($urandom_range(1, 6)) byte_buf.push_back(rand_byte());
        if ($urandom_range(0, 1))
            byte_buf[0] = 8'h00;
    endtask

    // queue the buffer as beats; mangle cuts it short, hits a byte or drops the end flag
    task automatic send_buffer(input bit mangle, input bit with_last);
        int r;
        int cut;
        int i;
        psse_pkg::item_t it;
        if (mangle) begin
            r = int'($urandom_range(0, 99));
            if (r < 8) begin
                cut = int'($urandom_range(1, byte_buf.size()));
                while (byte_buf.size() > cut)
                    byte_buf.delete(byte_buf.size() - 1);
            end else if (r < 12) begin
                byte_buf[$urandom_range(0, byte_buf.size() - 1)] = rand_byte();
            end
            if ($urandom_range(0, 99) < 8)
                with_last = 1'b0;
        end
        for (i = 0; i < byte_buf.size(); i++) begin
            it.data_byte = byte_buf[i];
            it.frame_start = (i == 0);
            it.last_byte = with_last && (i == byte_buf.size() - 1);
            pending.push_back(it);
        end
    endtask

    // queue random buffers until about amount source beats are pending
    task automatic run_random(input int amount);
        int queued;
        int r;
        queued = 0;
        while (queued < amount) begin
            r = int'($urandom_range(0, 99));
            if (r < 72)
                build_subpicture_buffer();
            else if (r < 86)
                build_broken_buffer();
            else
                build_noise_buffer();
            send_buffer(1'b1, 1'b1);
            queued = queued + byte_buf.size();
        end
    endtask

    task automatic wait_idle();
        while (pending.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [4:0] val);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == psse_pkg::REG_AUTO_SELECT)
            stim_auto = val[0];
        else
            stim_sub = val;
    endtask

    initial begin : stimulus
        logic [4:0] mid_sub;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // bad first byte, unknown type on the last byte, bad third byte on the last byte
        byte_buf = '{8'hFF};
        send_buffer(1'b0, 1'b1);
        byte_buf = '{8'h00, 8'h00, 8'h01, KIND_BOGUS};
        send_buffer(1'b0, 1'b1);
        byte_buf = '{8'h00, 8'h00, 8'h07};
        send_buffer(1'b0, 1'b1);
        // empty navigation packet, then buffer ends on a padding packet boundary
        byte_buf = '{8'h00, 8'h00, 8'h01, psse_pkg::KIND_NAV, 8'h00, 8'h00,
                     8'h00, 8'h00, 8'h01, psse_pkg::KIND_PADDING, 8'h00, 8'h01, 8'h55};
        send_buffer(1'b0, 1'b1);
        // error on the second byte, then a swallowed byte
        byte_buf = '{8'h00, 8'h01, 8'hAA};
        send_buffer(1'b0, 1'b1);
        // unfinished buffer cut off by the next frame start
        byte_buf = '{8'h00, 8'h00, 8'h01};
        send_buffer(1'b0, 1'b0);

        run_random(140);

        wait_idle();
        write_reg(psse_pkg::REG_AUTO_SELECT, 5'd0);
        write_reg(psse_pkg::REG_SUBSTREAM_INDEX, 5'd31);
        run_random(140);

        wait_idle();
        write_reg(psse_pkg::REG_SUBSTREAM_INDEX, 5'd0);
        run_random(140);

        wait_idle();
        mid_sub = 5'($urandom_range(1, 30));
        write_reg(psse_pkg::REG_SUBSTREAM_INDEX, mid_sub);
        run_random(140);

        wait_idle();
        write_reg(psse_pkg::REG_AUTO_SELECT, 5'd1);
        write_reg(psse_pkg::REG_SUBSTREAM_INDEX, 5'd21);
        run_random(140);

        // packet length using both length bytes, then a small subpicture
        wait_idle();
        byte_buf.delete();
        spic_bytes = '{8'h00, 8'h04, rand_byte(), rand_byte()};
        add_pack_header();
        add_skip_packet(psse_pkg::KIND_PADDING, 16'h0105);
        add_private(5'($urandom_range(0, 31)), 1, 4, 1'b1);
        send_buffer(1'b0, 1'b1);

        wait_idle();
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
